### rtl/core/dftfi_pkg.sv
`default_nettype none

package dftfi_pkg;

    localparam int POINTS      = 64;
    localparam int TW_BITS     = 16;
    localparam int LOG2_POINTS = $clog2(POINTS);
    localparam int TW_FRAC     = TW_BITS - 1;

    localparam int SAMPLE_W = 24;
    localparam int BIN_W    = 32;
    localparam int INDEX_W  = 6;
    localparam int PROD_W   = SAMPLE_W + TW_BITS;
    localparam int TERM_W   = PROD_W + 1;
    localparam int ACC_W    = TERM_W + LOG2_POINTS;

    localparam int SHIFT_FWD = TW_FRAC;
    localparam int SHIFT_INV = TW_FRAC + LOG2_POINTS;

    localparam int S_TDATA_W = 2 * SAMPLE_W;
    localparam int M_TDATA_W = ((2 * BIN_W + INDEX_W + 7) / 8) * 8;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [TW_BITS-1:0]  t_tw;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [TERM_W-1:0]   t_term;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic signed [BIN_W-1:0]    t_bin;
    typedef logic [LOG2_POINTS-1:0]     t_pidx;
    typedef t_tw                        t_tw_table [POINTS];

    localparam t_acc ACC_MAX = ACC_W'(32'sh7FFF_FFFF);
    localparam t_acc ACC_MIN = ~ACC_MAX;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_FLUSH,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic  issue;
        logic  clear;
        logic  inverse;
        t_pidx phase;
    } t_mac_ctl;

    typedef struct packed {
        logic busy;
        t_bin res_re;
        t_bin res_im;
    } t_mac_sts;

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic logic [63:0] horner_term(input logic [63:0] t2,
                                                input logic [63:0] acc,
                                                input int sel);
        logic [63:0] q;
        logic [63:0] r;
        q = qmul(t2, acc);
        case (sel)
            0:       r = (q + 64'd78) / 156;
            1:       r = (q + 64'd55) / 110;
            2:       r = (q + 64'd36) / 72;
            3:       r = (q + 64'd21) / 42;
            4:       r = (q + 64'd10) / 20;
            5:       r = (q + 64'd3) / 6;
            6:       r = (q + 64'd91) / 182;
            7:       r = (q + 64'd66) / 132;
            8:       r = (q + 64'd45) / 90;
            9:       r = (q + 64'd28) / 56;
            10:      r = (q + 64'd15) / 30;
            11:      r = (q + 64'd6) / 12;
            12:      r = (q + 64'd1) / 2;
            default: r = q;
        endcase
        return (r >= Q30_ONE) ? 64'd0 : Q30_ONE - r;
    endfunction

    function automatic logic [63:0] to_rom(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] top;
        r   = (v + (64'd1 << (29 - TW_FRAC))) >> (30 - TW_FRAC);
        top = (64'd1 << TW_FRAC) - 64'd1;
        return (r > top) ? top : r;
    endfunction

    function automatic t_tw_table build_twiddle(input logic want_sin);
        t_tw_table   tab;
        logic [63:0] stepv;
        logic [63:0] f;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] acc;
        logic [63:0] s;
        logic [63:0] c;
        t_tw         sv;
        t_tw         cv;
        t_tw         tc;
        t_tw         ts;
        stepv = 64'd1 << (32 - LOG2_POINTS);
        for (int m = 0; m < POINTS; m++) begin
            f   = (64'(m) * stepv) & 64'hFFFF_FFFF;
            r   = f & (Q30_ONE - 64'd1);
            t   = (r * HALF_PI_Q30 + (64'd1 << 29)) >> 30;
            t2  = qmul(t, t);
            acc = Q30_ONE;
            for (int i = 0; i < 6; i++) begin
                acc = horner_term(t2, acc, i);
            end
            s   = to_rom(qmul(t, acc));
            acc = Q30_ONE;
            for (int i = 0; i < 7; i++) begin
                acc = horner_term(t2, acc, 6 + i);
            end
            c  = to_rom(acc);
            sv = TW_BITS'(s);
            cv = TW_BITS'(c);
            case (f[31:30])
                2'd0: begin
                    tc = cv;
                    ts = sv;
                end
                2'd1: begin
                    tc = -sv;
                    ts = cv;
                end
                2'd2: begin
                    tc = -cv;
                    ts = -sv;
                end
                default: begin
                    tc = sv;
                    ts = -cv;
                end
            endcase
            tab[m] = want_sin ? ts : tc;
        end
        return tab;
    endfunction

    localparam t_tw_table TW_COS = build_twiddle(1'b0);
    localparam t_tw_table TW_SIN = build_twiddle(1'b1);

    function automatic logic [INDEX_W-1:0] bin_idx(input t_pidx k);
        logic [31:0] w;
        w = 32'(k);
        return w[INDEX_W-1:0];
    endfunction

    function automatic t_bin sat_acc(input t_acc v);
        if (v > ACC_MAX) begin
            return t_bin'(ACC_MAX);
        end else if (v < ACC_MIN) begin
            return t_bin'(ACC_MIN);
        end
        return t_bin'(v);
    endfunction

endpackage

`default_nettype wire

### rtl/core/complex_dft_forward_inverse.sv
// channel  dir  handshake                   payload
// s_axis   in   s_axis_tvalid/tready        tdata: sample_real, sample_imag
// m_axis   out  m_axis_tvalid/tready        tdata: bin_real, bin_imag, bin_index; tlast: last_bin
// cfg      in   i_cfg_we                    i_cfg_wdata: inverse_mode
//
// Samples load one per cycle; the item that completes a block starts the transform.
// Each bin issues one complex MAC per cycle on the sample RAM read port, one per sample,
// then drains the MAC pipeline in ST_FLUSH and presents the bin in ST_EMIT.
// s_axis_tready is low while the transform runs; a stalled m_axis holds the next bin.
// Reset is synchronous, active low, and clears control only; the sample RAM needs no clear.
`default_nettype none

module complex_dft_forward_inverse (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [23:0] sample_real, [47:24] sample_imag
    input  wire logic [dftfi_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [31:0] bin_real, [63:32] bin_imag, [69:64] bin_index, rest zero
    output logic [dftfi_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tlast
);

    logic                                 ram_we;
    dftfi_pkg::t_pidx                     ram_waddr;
    dftfi_pkg::t_pidx                     ram_raddr;
    logic [dftfi_pkg::S_TDATA_W-1:0]      ram_rdata;
    dftfi_pkg::t_mac_ctl                  mac_ctl;
    dftfi_pkg::t_mac_sts                  mac_sts;
    dftfi_pkg::t_bin                      bin_re;
    dftfi_pkg::t_bin                      bin_im;
    logic [dftfi_pkg::INDEX_W-1:0]        bin_index;

    dftfi_ram #(
        .WIDTH (dftfi_pkg::S_TDATA_W),
        .DEPTH (dftfi_pkg::POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (s_axis_tdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dftfi_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_x_re  (ram_rdata[dftfi_pkg::SAMPLE_W-1:0]),
        .i_x_im  (ram_rdata[dftfi_pkg::S_TDATA_W-1:dftfi_pkg::SAMPLE_W]),
        .o_sts   (mac_sts)
    );

    dftfi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_bin_re    (bin_re),
        .o_bin_im    (bin_im),
        .o_bin_index (bin_index),
        .o_bin_last  (m_axis_tlast),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_raddr (ram_raddr),
        .o_mac_ctl   (mac_ctl),
        .i_mac_sts   (mac_sts)
    );

    assign m_axis_tdata = dftfi_pkg::M_TDATA_W'({bin_index, bin_im, bin_re});

endmodule

`default_nettype wire

### rtl/core/dftfi_ram.sv
`default_nettype none

module dftfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/dftfi_mac.sv
`default_nettype none

module dftfi_mac (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire dftfi_pkg::t_mac_ctl  i_ctl,
    input  wire dftfi_pkg::t_sample   i_x_re,
    input  wire dftfi_pkg::t_sample   i_x_im,
    output dftfi_pkg::t_mac_sts       o_sts
);

    logic r_v1;
    logic r_v2;
    logic r_v3;

    dftfi_pkg::t_tw   r_cos;
    dftfi_pkg::t_tw   r_sin;
    dftfi_pkg::t_prod r_p_rc;
    dftfi_pkg::t_prod r_p_is;
    dftfi_pkg::t_prod r_p_ic;
    dftfi_pkg::t_prod r_p_rs;
    dftfi_pkg::t_term r_t_re;
    dftfi_pkg::t_term r_t_im;
    dftfi_pkg::t_acc  r_acc_re;
    dftfi_pkg::t_acc  r_acc_im;

    dftfi_pkg::t_term n_t_re;
    dftfi_pkg::t_term n_t_im;
    dftfi_pkg::t_acc  sh_re;
    dftfi_pkg::t_acc  sh_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        if (i_ctl.inverse) begin
            n_t_re = dftfi_pkg::TERM_W'(r_p_rc) - dftfi_pkg::TERM_W'(r_p_is);
            n_t_im = dftfi_pkg::TERM_W'(r_p_rs) + dftfi_pkg::TERM_W'(r_p_ic);
        end else begin
            n_t_re = dftfi_pkg::TERM_W'(r_p_rc) + dftfi_pkg::TERM_W'(r_p_is);
            n_t_im = dftfi_pkg::TERM_W'(r_p_ic) - dftfi_pkg::TERM_W'(r_p_rs);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cos  <= dftfi_pkg::TW_COS[i_ctl.phase];
        r_sin  <= dftfi_pkg::TW_SIN[i_ctl.phase];
        r_p_rc <= dftfi_pkg::PROD_W'(i_x_re) * dftfi_pkg::PROD_W'(r_cos);
        r_p_is <= dftfi_pkg::PROD_W'(i_x_im) * dftfi_pkg::PROD_W'(r_sin);
        r_p_ic <= dftfi_pkg::PROD_W'(i_x_im) * dftfi_pkg::PROD_W'(r_cos);
        r_p_rs <= dftfi_pkg::PROD_W'(i_x_re) * dftfi_pkg::PROD_W'(r_sin);
        r_t_re <= n_t_re;
        r_t_im <= n_t_im;
        if (i_ctl.clear) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_v3) begin
            r_acc_re <= r_acc_re + dftfi_pkg::ACC_W'(r_t_re);
            r_acc_im <= r_acc_im + dftfi_pkg::ACC_W'(r_t_im);
        end
    end

    always_comb begin
        if (i_ctl.inverse) begin
            sh_re = r_acc_re >>> dftfi_pkg::SHIFT_INV;
            sh_im = r_acc_im >>> dftfi_pkg::SHIFT_INV;
        end else begin
            sh_re = r_acc_re >>> dftfi_pkg::SHIFT_FWD;
            sh_im = r_acc_im >>> dftfi_pkg::SHIFT_FWD;
        end
        o_sts.busy   = r_v1 | r_v2 | r_v3;
        o_sts.res_re = dftfi_pkg::sat_acc(sh_re);
        o_sts.res_im = dftfi_pkg::sat_acc(sh_im);
    end

endmodule

`default_nettype wire

### rtl/core/dftfi_ctrl.sv
`default_nettype none

module dftfi_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_wdata,
    input  wire logic                            i_s_valid,
    output logic                                 o_s_ready,
    input  wire logic                            i_m_ready,
    output logic                                 o_m_valid,
    output dftfi_pkg::t_bin                      o_bin_re,
    output dftfi_pkg::t_bin                      o_bin_im,
    output logic [dftfi_pkg::INDEX_W-1:0]        o_bin_index,
    output logic                                 o_bin_last,
    output logic                                 o_ram_we,
    output dftfi_pkg::t_pidx                     o_ram_waddr,
    output dftfi_pkg::t_pidx                     o_ram_raddr,
    output dftfi_pkg::t_mac_ctl                  o_mac_ctl,
    input  wire dftfi_pkg::t_mac_sts             i_mac_sts
);

    dftfi_pkg::t_state r_state;
    dftfi_pkg::t_state n_state;

    logic              r_inverse;
    dftfi_pkg::t_pidx  r_load_cnt;
    dftfi_pkg::t_pidx  r_n;
    dftfi_pkg::t_pidx  r_k;
    dftfi_pkg::t_pidx  r_phase;
    logic              r_out_valid;
    dftfi_pkg::t_pidx  n_load_cnt;
    dftfi_pkg::t_pidx  n_n;
    dftfi_pkg::t_pidx  n_k;
    dftfi_pkg::t_pidx  n_phase;
    logic              n_out_valid;

    dftfi_pkg::t_bin              r_out_re;
    dftfi_pkg::t_bin              r_out_im;
    logic [dftfi_pkg::INDEX_W-1:0] r_out_idx;
    logic                         r_out_last;

    logic accept;
    logic load_done;
    logic n_last;
    logic k_last;
    logic take;
    logic out_load;

    assign accept    = i_s_valid && (r_state == dftfi_pkg::ST_LOAD);
    assign load_done = accept && (r_load_cnt == dftfi_pkg::t_pidx'(dftfi_pkg::POINTS - 1));
    assign n_last    = (r_n == dftfi_pkg::t_pidx'(dftfi_pkg::POINTS - 1));
    assign k_last    = (r_k == dftfi_pkg::t_pidx'(dftfi_pkg::POINTS - 1));
    assign take      = !r_out_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dftfi_pkg::ST_LOAD: begin
                if (load_done) begin
                    n_state = dftfi_pkg::ST_RUN;
                end
            end
            dftfi_pkg::ST_RUN: begin
                if (n_last) begin
                    n_state = dftfi_pkg::ST_FLUSH;
                end
            end
            dftfi_pkg::ST_FLUSH: begin
                if (!i_mac_sts.busy) begin
                    n_state = dftfi_pkg::ST_EMIT;
                end
            end
            dftfi_pkg::ST_EMIT: begin
                if (take) begin
                    n_state = k_last ? dftfi_pkg::ST_LOAD : dftfi_pkg::ST_RUN;
                end
            end
            default: n_state = dftfi_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        o_s_ready         = (r_state == dftfi_pkg::ST_LOAD);
        out_load          = (r_state == dftfi_pkg::ST_EMIT) && take;
        o_mac_ctl.issue   = (r_state == dftfi_pkg::ST_RUN);
        o_mac_ctl.clear   = load_done || (out_load && !k_last);
        o_mac_ctl.inverse = r_inverse;
        o_mac_ctl.phase   = r_phase;
        o_ram_we          = accept;
        o_ram_waddr       = r_load_cnt;
        o_ram_raddr       = r_n;
    end

    always_comb begin
        n_load_cnt  = accept ? r_load_cnt + 1'b1 : r_load_cnt;
        n_n         = r_n;
        n_k         = r_k;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && !i_m_ready;
        if (load_done) begin
            n_n     = '0;
            n_k     = '0;
            n_phase = '0;
        end
        if (r_state == dftfi_pkg::ST_RUN) begin
            n_n     = r_n + 1'b1;
            n_phase = r_phase + r_k;
        end
        if (out_load) begin
            n_out_valid = 1'b1;
            n_n         = '0;
            n_phase     = '0;
            n_k         = r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dftfi_pkg::ST_LOAD;
            r_inverse   <= 1'b0;
            r_load_cnt  <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_cnt  <= n_load_cnt;
            r_n         <= n_n;
            r_k         <= n_k;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_inverse <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_re   <= i_mac_sts.res_re;
            r_out_im   <= i_mac_sts.res_im;
            r_out_idx  <= dftfi_pkg::bin_idx(r_k);
            r_out_last <= k_last;
        end
    end

    assign o_m_valid   = r_out_valid;
    assign o_bin_re    = r_out_re;
    assign o_bin_im    = r_out_im;
    assign o_bin_index = r_out_idx;
    assign o_bin_last  = r_out_last;

endmodule

`default_nettype wire

### bench/tb_complex_dft_forward_inverse.sv
`timescale 1ns / 1ps

module tb_complex_dft_forward_inverse;

    localparam int POINTS      = dftfi_pkg::POINTS;
    localparam int LOG2_POINTS = dftfi_pkg::LOG2_POINTS;
    localparam int TW_FRAC     = dftfi_pkg::TW_FRAC;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 16;
    localparam int END_SETTLE  = 200;
    localparam int REPORT_MAX  = 10;

    localparam logic MODE_FWD = 1'b0;
    localparam logic MODE_INV = 1'b1;

    localparam longint unsigned ONE_Q30     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TW_TOP      = (64'd1 << TW_FRAC) - 64'd1;
    localparam logic [6*8-1:0] SIN_DEN = {8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
    localparam logic [7*8-1:0] COS_DEN = {8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};
    localparam logic [8*24-1:0] EDGE_VALUES = {
        24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
        24'h000001, 24'h555555, 24'hAAAAAA, 24'h400000
    };
    localparam longint BIN_HI = 64'sd2147483647;
    localparam longint BIN_LO = -64'sd2147483648;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [5:0]         kbin;
        logic               last;
    } spectral_bin_t;

    logic i_clk         = 1'b0;
    logic i_rst_n       = 1'b0;
    logic i_cfg_we      = 1'b0;
    logic i_cfg_wdata   = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic m_axis_tready = 1'b0;
    logic s_axis_tready;
    logic m_axis_tvalid;
    logic m_axis_tlast;
    // [23:0] sample_real, [47:24] sample_imag
    logic [dftfi_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    // [31:0] bin_real, [63:32] bin_imag, [69:64] bin_index, rest zero
    logic [dftfi_pkg::M_TDATA_W-1:0] m_axis_tdata;

    dftfi_pkg::t_tw     tw_cos [POINTS];
    dftfi_pkg::t_tw     tw_sin [POINTS];
    dftfi_pkg::t_sample samp_re [POINTS];
    dftfi_pkg::t_sample samp_im [POINTS];
    logic               inv_mode = MODE_FWD;
    int                 fill_count = 0;
    spectral_bin_t      pending_bins [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int samples_sent  = 0;
    int transforms    = 0;
    int bins_seen     = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    complex_dft_forward_inverse dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint unsigned fx_mul(input longint unsigned a,
                                               input longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint unsigned series_step(input longint unsigned t2,
                                                    input longint unsigned acc,
                                                    input longint unsigned den);
        longint unsigned q;
        q = (fx_mul(t2, acc) + den / 2) / den;
        return (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
    endfunction

    function automatic dftfi_pkg::t_tw round_to_tw(input longint unsigned v);
        longint unsigned q;
        dftfi_pkg::t_tw  w;
        q = (v + (64'd1 << (29 - TW_FRAC))) >> (30 - TW_FRAC);
        if (q > TW_TOP) begin
            q = TW_TOP;
        end
        w = 16'(q);
        return w;
    endfunction

    function automatic void build_twiddles();
        longint unsigned f;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned acc;
        dftfi_pkg::t_tw  s;
        dftfi_pkg::t_tw  c;
        for (int m = 0; m < POINTS; m++) begin
            f  = (64'(m) << (32 - LOG2_POINTS)) & 64'hFFFF_FFFF;
            t  = ((f & (ONE_Q30 - 64'd1)) * HALF_PI_Q30 + (64'd1 << 29)) >> 30;
            t2 = fx_mul(t, t);
            acc = ONE_Q30;
            for (int i = 0; i < 6; i++) begin
                acc = series_step(t2, acc, 64'(SIN_DEN[i*8 +: 8]));
            end
            s = round_to_tw(fx_mul(t, acc));
            acc = ONE_Q30;
            for (int i = 0; i < 7; i++) begin
                acc = series_step(t2, acc, 64'(COS_DEN[i*8 +: 8]));
            end
            c = round_to_tw(acc);
            case (f[31:30])
                2'd0: begin
                    tw_cos[m] = c;
                    tw_sin[m] = s;
                end
                2'd1: begin
                    tw_cos[m] = -s;
                    tw_sin[m] = c;
                end
                2'd2: begin
                    tw_cos[m] = -c;
                    tw_sin[m] = -s;
                end
                default: begin
                    tw_cos[m] = s;
                    tw_sin[m] = -c;
                end
            endcase
        end
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > BIN_HI) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < BIN_LO) begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    function automatic void predict_spectrum();
        longint        acc_re;
        longint        acc_im;
        longint        xr;
        longint        xi;
        longint        c;
        longint        s;
        int            shift;
        int            tw_idx;
        spectral_bin_t b;
        shift = TW_FRAC + ((inv_mode == MODE_INV) ? LOG2_POINTS : 0);
        for (int k = 0; k < POINTS; k++) begin
            acc_re = 0;
            acc_im = 0;
            for (int n = 0; n < POINTS; n++) begin
                tw_idx = (n * k) & (POINTS - 1);
                c  = tw_cos[tw_idx];
                s  = tw_sin[tw_idx];
                xr = samp_re[n];
                xi = samp_im[n];
                if (inv_mode == MODE_INV) begin
                    acc_re += xr * c - xi * s;
                    acc_im += xr * s + xi * c;
                end else begin
                    acc_re += xr * c + xi * s;
                    acc_im += xi * c - xr * s;
                end
            end
            b.re   = clamp32(acc_re >>> shift);
            b.im   = clamp32(acc_im >>> shift);
            b.kbin = 6'(k);
            b.last = (k == POINTS - 1);
            pending_bins.push_back(b);
        end
    endfunction

    function automatic void store_sample(input dftfi_pkg::t_sample re,
                                         input dftfi_pkg::t_sample im);
        samp_re[fill_count] = re;
        samp_im[fill_count] = im;
        fill_count++;
        samples_sent++;
        if (fill_count == POINTS) begin
            fill_count = 0;
            transforms++;
            predict_spectrum();
        end
    endfunction

    function automatic dftfi_pkg::t_sample rand_sample();
        dftfi_pkg::t_sample v;
        case ($urandom_range(4))
            0, 1:    v = 24'($urandom);
            2:       v = 24'($urandom_range(511)) - 24'd256;
            3:       v = EDGE_VALUES[$urandom_range(7)*24 +: 24];
            default: v = 24'($urandom) >>> $urandom_range(20);
        endcase
        return v;
    endfunction

    task automatic send_sample(input dftfi_pkg::t_sample re, input dftfi_pkg::t_sample im);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {im, re};
        do @(posedge i_clk); while (!s_axis_tready);
        store_sample(re, im);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_sample(rand_sample(), rand_sample());
        end
    endtask

    // hold the sender until every predicted bin has arrived
    task automatic wait_for_spectrum();
        s_axis_tvalid <= 1'b0;
        while (pending_bins.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic mode);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        inv_mode     = mode;
    endtask

    task automatic test_forward_extremes();
        set_mode(MODE_FWD);
        for (int i = 0; i < 8; i++) begin
            send_sample(EDGE_VALUES[i*24 +: 24], EDGE_VALUES[i*24 +: 24]);
        end
        for (int i = 0; i < 8; i++) begin
            send_sample(EDGE_VALUES[i*24 +: 24], EDGE_VALUES[(7-i)*24 +: 24]);
        end
        send_random(POINTS - 16);
        wait_for_spectrum();
    endtask

    task automatic test_inverse_random();
        set_mode(MODE_INV);
        send_random(POINTS);
        wait_for_spectrum();
    endtask

    // only the mode present when the block completes counts
    task automatic test_mode_switch_midload();
        send_random(20);
        wait_for_spectrum();
        set_mode(MODE_FWD);
        send_random(24);
        wait_for_spectrum();
        set_mode(MODE_INV);
        send_random(POINTS - 44);
        wait_for_spectrum();
    endtask

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        spectral_bin_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            bins_seen++;
            if (pending_bins.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected bin: re=%0d im=%0d k=%0d last=%0b",
                             $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
                             m_axis_tdata[69:64], m_axis_tlast);
                end
            end else begin
                want = pending_bins.pop_front();
                if (m_axis_tdata[31:0] !== want.re || m_axis_tdata[63:32] !== want.im ||
                    m_axis_tdata[69:64] !== want.kbin || m_axis_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("bin %0d: expected re=%0d im=%0d k=%0d last=%0b",
                                 want.kbin, want.re, want.im, want.kbin, want.last);
                        $display("        got      re=%0d im=%0d k=%0d last=%0b",
                                 $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]),
                                 m_axis_tdata[69:64], m_axis_tlast);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("complex_dft_forward_inverse: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        build_twiddles();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 15;
        recv_idle_pct = 68;
        test_forward_extremes();

        send_idle_pct = 68;
        recv_idle_pct = 15;
        test_inverse_random();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_mode_switch_midload();

        repeat (END_SETTLE) @(posedge i_clk);
        if (pending_bins.size() != 0) begin
            $display("%0d bins never arrived", pending_bins.size());
            mismatches++;
        end
        $display("run: %0d samples, %0d transforms (forward, inverse, mode change mid-block)",
                 samples_sent, transforms);
        $display("run: %0d bins compared, %0d bad", bins_seen, mismatches);
        if (mismatches == 0) begin
            $display("complex_dft_forward_inverse: match");
        end else begin
            $display("complex_dft_forward_inverse: mismatch");
        end
        $finish;
    end

endmodule
